>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers used by the tag model RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Check that a condition in one cycle implies another in the next.
`define ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/dmc_pkg.sv
// ----------------------------------------------------------------------------
// dmc_pkg
// Types and constants of the direct-mapped cache tag model.
// ----------------------------------------------------------------------------
package dmc_pkg;

    localparam int MAX_SETS_DEF = 1024;
    localparam int ADDR_BITS    = 32;
    localparam int ADDR_W       = 32;
    localparam int TAG_W        = 30;
    localparam int QUEUE_DEPTH  = 2;
    localparam int WORD_LOG2    = 2;

    localparam logic [ADDR_W-1:0] ADDR_MASK =
        (ADDR_BITS >= ADDR_W) ? '1 : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_STORE = 2'd1;
    localparam logic [1:0] MODE_FETCH = 2'd2;
    localparam logic [1:0] MODE_RSVD  = 2'd3;

    localparam logic [2:0] REG_SPLIT      = 3'd0;
    localparam logic [2:0] REG_BLOCK_OFS  = 3'd1;
    localparam logic [2:0] REG_INST_IDX   = 3'd2;
    localparam logic [2:0] REG_DATA_IDX   = 3'd3;
    localparam logic [2:0] REG_WRITE_BACK = 3'd4;
    localparam logic [2:0] REG_WRITE_ALLOC = 3'd5;

    typedef struct packed {
        logic       split_mode;
        logic [2:0] block_offset_bits;
        logic [3:0] inst_index_bits;
        logic [3:0] data_index_bits;
        logic       write_back;
        logic       write_allocate;
    } dmc_cfg_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [1:0]       mode;
        logic             use_data;
    } dmc_req_t;

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [TAG_W-1:0] tag;
    } dmc_line_t;

    typedef struct packed {
        logic       to_data_side;
        logic [6:0] copyback_words;
        logic [5:0] fetch_words;
        logic       allocated;
        logic       evicted;
        logic       hit;
    } dmc_rsp_t;

    typedef struct packed {
        logic clear_busy;
    } dmc_status_t;

endpackage

>>> rtl/dmc_queue.sv
// ----------------------------------------------------------------------------
// dmc_queue
// Short request queue between the classifying front end and the tag engine.
// ----------------------------------------------------------------------------
module dmc_queue #(
    parameter int IDX_W = 10,
    parameter int DEPTH = dmc_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  dmc_pkg::dmc_req_t push_req,
    input  logic [IDX_W-1:0]  push_idx,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output dmc_pkg::dmc_req_t head_req,
    output logic [IDX_W-1:0]  head_idx
);
    import dmc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dmc_req_t             req_mem [DEPTH];
    logic [IDX_W-1:0]     idx_mem [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_req   = req_mem[rd_ptr_reg];
    assign head_idx   = idx_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            req_mem[wr_ptr_reg] <= push_req;
            idx_mem[wr_ptr_reg] <= push_idx;
        end
    end

endmodule

>>> rtl/dmc_front.sv
// ----------------------------------------------------------------------------
// dmc_front
// Classifies a traced access: picks the cache, splits the address into set
// index and tag under the current geometry.
// ----------------------------------------------------------------------------
module dmc_front #(
    parameter int MAX_SETS = dmc_pkg::MAX_SETS_DEF
) (
    input  dmc_pkg::dmc_cfg_t cfg,
    input  logic [31:0]       address,
    input  logic [1:0]        mode,
    output dmc_pkg::dmc_req_t req,
    output logic [((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0] idx
);
    import dmc_pkg::*;

    localparam int IDX_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int IDX_LIMIT = $clog2(MAX_SETS + 1) - 1;

    logic [ADDR_W-1:0] addr_m;
    logic              use_data;
    logic [2:0]        bob;
    logic [3:0]        ib_cfg;
    logic [4:0]        ib;
    logic [4:0]        tag_shift;
    logic [ADDR_W-1:0] idx_full;
    logic [IDX_W-1:0]  idx_mask;

    always_comb begin
        addr_m    = address & ADDR_MASK;
        use_data  = cfg.split_mode && (mode != MODE_FETCH);
        bob       = (cfg.block_offset_bits < 3'd2) ? 3'd2 : cfg.block_offset_bits;
        ib_cfg    = use_data ? cfg.data_index_bits : cfg.inst_index_bits;
        ib        = ({1'b0, ib_cfg} > 5'(IDX_LIMIT)) ? 5'(IDX_LIMIT) : {1'b0, ib_cfg};
        tag_shift = {2'b00, bob} + ib;
        idx_full  = addr_m >> bob;
        for (int i = 0; i < IDX_W; i++) begin
            idx_mask[i] = (5'(i) < ib);
        end
        idx          = idx_full[IDX_W-1:0] & idx_mask;
        req.tag      = TAG_W'(addr_m >> tag_shift);
        req.mode     = mode;
        req.use_data = use_data;
    end

endmodule

>>> rtl/dmc_back.sv
// ----------------------------------------------------------------------------
// dmc_back
// Tag engine: clears the tag stores after reset, then per request reads one
// set, resolves hit, victim and traffic, writes the set back on a fill or a
// write-back store hit, and registers the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dmc_back #(
    parameter int MAX_SETS = dmc_pkg::MAX_SETS_DEF,
    parameter int IDX_W    = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dmc_pkg::dmc_cfg_t    cfg,
    input  logic                 q_valid,
    input  dmc_pkg::dmc_req_t    q_req,
    input  logic [IDX_W-1:0]     q_idx,
    output logic                 q_pop,
    output dmc_pkg::dmc_status_t status,
    output logic                 m_valid,
    input  logic                 m_ready,
    output dmc_pkg::dmc_rsp_t    m_rsp
);
    import dmc_pkg::*;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_RESOLVE} state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] clr_cnt_reg;
    dmc_req_t         req_reg;
    logic [IDX_W-1:0] idx_reg;
    dmc_line_t        rd_inst_reg;
    dmc_line_t        rd_data_reg;
    logic             m_valid_reg;
    dmc_rsp_t         rsp_reg;
    dmc_rsp_t         rsp_next;

    dmc_line_t        inst_mem [MAX_SETS];
    dmc_line_t        data_mem [MAX_SETS];

    dmc_line_t        line;
    logic             clearing;
    logic             out_free;
    logic             is_store;
    logic             is_rsvd;
    logic             hit;
    logic             fill;
    logic [2:0]       bob;
    logic [5:0]       words;
    logic [6:0]       cb_victim;
    logic [6:0]       cb_through;
    logic             wr_en;
    logic             inst_we;
    logic             data_we;
    logic [IDX_W-1:0] wr_idx;
    dmc_line_t        wr_line;

    assign clearing          = (state_reg == ST_CLEAR);
    assign out_free          = !m_valid_reg || m_ready;
    assign q_pop             = (state_reg == ST_IDLE) && q_valid;
    assign status.clear_busy = clearing;
    assign m_valid           = m_valid_reg;
    assign m_rsp             = rsp_reg;

    always_comb begin
        line       = req_reg.use_data ? rd_data_reg : rd_inst_reg;
        is_store   = (req_reg.mode == MODE_STORE);
        is_rsvd    = (req_reg.mode == MODE_RSVD);
        bob        = (cfg.block_offset_bits < 3'd2) ? 3'd2 : cfg.block_offset_bits;
        words      = 6'd1 << (bob - 3'(WORD_LOG2));
        hit        = line.valid && (line.tag == req_reg.tag);
        fill       = !hit && (!is_store || cfg.write_allocate);
        cb_victim  = (line.valid && line.dirty) ? {1'b0, words} : 7'd0;
        cb_through = (is_store && !cfg.write_back) ? {1'b0, words} : 7'd0;

        rsp_next = '0;
        if (!is_rsvd) begin
            rsp_next.to_data_side = (req_reg.mode != MODE_FETCH);
            rsp_next.hit          = hit;
            if (fill) begin
                rsp_next.evicted        = line.valid;
                rsp_next.allocated      = 1'b1;
                rsp_next.fetch_words    = words;
                rsp_next.copyback_words = cb_victim + cb_through;
            end
        end

        wr_en = (state_reg == ST_RESOLVE) && out_free && !is_rsvd &&
                (hit ? (is_store && cfg.write_back) : fill);
        if (clearing) begin
            wr_line = '0;
            wr_idx  = clr_cnt_reg;
        end else begin
            wr_line.valid = 1'b1;
            wr_line.dirty = hit ? 1'b1 : (is_store && cfg.write_back);
            wr_line.tag   = req_reg.tag;
            wr_idx        = idx_reg;
        end
        inst_we = clearing || (wr_en && !req_reg.use_data);
        data_we = clearing || (wr_en && req_reg.use_data);
    end

    always_ff @(posedge aclk) begin
        if (inst_we) begin
            inst_mem[wr_idx] <= wr_line;
        end
        if (data_we) begin
            data_mem[wr_idx] <= wr_line;
        end
        if (q_pop) begin
            rd_inst_reg <= inst_mem[q_idx];
            rd_data_reg <= data_mem[q_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == IDX_W'(MAX_SETS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (q_valid) begin
                        req_reg   <= q_req;
                        idx_reg   <= q_idx;
                        state_reg <= ST_RESOLVE;
                    end
                end
                ST_RESOLVE: begin
                    if (out_free) begin
                        rsp_reg   <= rsp_next;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if ((state_reg == ST_RESOLVE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    `ASSERT_CLK(a_no_pop_in_clear, aclk, aresetn, clearing |-> !q_pop, "pop during clearing pass")
    `ASSERT_CLK(a_hit_never_fills, aclk, aresetn, m_valid_reg |-> !(rsp_reg.hit && rsp_reg.allocated), "hit with fill")
    `ASSERT_CLK(a_fetch_on_fill, aclk, aresetn, m_valid_reg |-> ((rsp_reg.fetch_words != 6'd0) == rsp_reg.allocated), "fetch without fill")
    `ASSERT_NEXT(a_resolve_returns, aclk, aresetn, (state_reg == ST_RESOLVE) && out_free, state_reg == ST_IDLE, "resolve did not finish")

endmodule

>>> rtl/direct_mapped_cache_tag_model.sv
// ----------------------------------------------------------------------------
// direct_mapped_cache_tag_model
// Direct-mapped tag store model, unified or split, write-back or
// write-through, with optional write allocation; reports hit, eviction and
// word traffic for each traced access.
// ----------------------------------------------------------------------------
// After reset the block sweeps both tag stores, one set per cycle; s_tready
// stays low during that sweep. Each access then reads its set from the tag
// memory, then resolves and writes any change back; the tag engine takes the
// next access only once the last is resolved. A two-entry queue decouples
// input acceptance from the engine, and the result register lets the next
// access read its set while a result waits on m_tready, though it resolves
// only once that result is taken. Write configuration registers only while
// no access is in flight.
module direct_mapped_cache_tag_model #(
    parameter int MAX_SETS = dmc_pkg::MAX_SETS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // access input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] address
    input  logic [1:0]  s_tuser,   // [1:0] mode
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] hit, [1] evicted, [2] allocated,
                                   // [8:3] fetch_words, [15:9] copyback_words
    output logic        m_tuser    // [0] to_data_side
);
    import dmc_pkg::*;

    localparam int IDX_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;

    dmc_cfg_t         cfg_reg;
    logic             cfg_we;
    logic [2:0]       reg_sel;
    dmc_req_t         f_req;
    logic [IDX_W-1:0] f_idx;
    logic             q_full;
    logic             q_push;
    logic             q_pop;
    logic             q_valid;
    dmc_req_t         q_req;
    logic [IDX_W-1:0] q_idx;
    dmc_status_t      status;
    dmc_rsp_t         rsp;

    assign pready  = 1'b1;
    assign reg_sel = paddr[4:2];
    assign cfg_we  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.split_mode        <= 1'b0;
            cfg_reg.block_offset_bits <= 3'd4;
            cfg_reg.inst_index_bits   <= 4'd10;
            cfg_reg.data_index_bits   <= 4'd10;
            cfg_reg.write_back        <= 1'b1;
            cfg_reg.write_allocate    <= 1'b1;
        end else if (cfg_we) begin
            case (reg_sel)
                REG_SPLIT:       cfg_reg.split_mode        <= pwdata[0];
                REG_BLOCK_OFS:   cfg_reg.block_offset_bits <= pwdata[2:0];
                REG_INST_IDX:    cfg_reg.inst_index_bits   <= pwdata[3:0];
                REG_DATA_IDX:    cfg_reg.data_index_bits   <= pwdata[3:0];
                REG_WRITE_BACK:  cfg_reg.write_back        <= pwdata[0];
                REG_WRITE_ALLOC: cfg_reg.write_allocate    <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_SPLIT:       prdata = {31'd0, cfg_reg.split_mode};
            REG_BLOCK_OFS:   prdata = {29'd0, cfg_reg.block_offset_bits};
            REG_INST_IDX:    prdata = {28'd0, cfg_reg.inst_index_bits};
            REG_DATA_IDX:    prdata = {28'd0, cfg_reg.data_index_bits};
            REG_WRITE_BACK:  prdata = {31'd0, cfg_reg.write_back};
            REG_WRITE_ALLOC: prdata = {31'd0, cfg_reg.write_allocate};
            default:         prdata = 32'd0;
        endcase
    end

    assign s_tready = !q_full && !status.clear_busy;
    assign q_push   = s_tvalid && s_tready;

    dmc_front #(
        .MAX_SETS (MAX_SETS)
    ) u_front (
        .cfg     (cfg_reg),
        .address (s_tdata),
        .mode    (s_tuser),
        .req     (f_req),
        .idx     (f_idx)
    );

    dmc_queue #(
        .IDX_W (IDX_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_req   (f_req),
        .push_idx   (f_idx),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_req   (q_req),
        .head_idx   (q_idx)
    );

    dmc_back #(
        .MAX_SETS (MAX_SETS),
        .IDX_W    (IDX_W)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_req   (q_req),
        .q_idx   (q_idx),
        .q_pop   (q_pop),
        .status  (status),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_rsp   (rsp)
    );

    assign m_tdata = {rsp.copyback_words, rsp.fetch_words, rsp.allocated,
                      rsp.evicted, rsp.hit};
    assign m_tuser = rsp.to_data_side;

endmodule
